/* sv/qft_pkg.sv */
// Shared types, constants and helpers for the quoted field tokenizer.
`default_nettype none
package qft_pkg;

  localparam int unsigned SetChars = 4;
  localparam int unsigned CharW    = 8;
  localparam int unsigned SetW     = SetChars * CharW;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned ResCntW  = $clog2(MaxRes + 1);

  localparam logic [CharW-1:0] Backslash = 8'h5C;
  localparam logic [CharW-1:0] CountMax  = 8'hFF;

  localparam logic [ModeW-1:0] ModeReset    = 3'd0;
  localparam logic [CharW-1:0] MaxFldReset  = 8'd0;
  localparam logic [SetW-1:0]  DelimReset   = 32'h0000_0920;
  localparam logic [SetW-1:0]  QuoteReset   = 32'h0000_2227;
  localparam logic [SetW-1:0]  CommentReset = 32'h0000_0023;

  // mode bit positions
  localparam int unsigned ModeEmpty  = 0;
  localparam int unsigned ModeDos    = 1;
  localparam int unsigned ModeNoEsc  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMode     = 3'd0,
    CfgMaxFlds  = 3'd1,
    CfgDelim    = 3'd2,
    CfgQuote    = 3'd3,
    CfgComment  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KindChar     = 2'd0,
    KindFieldEnd = 2'd1,
    KindLineOk   = 2'd2,
    KindLineOpen = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PhStart  = 3'd0,
    PhSkip   = 3'd1,
    PhCheck  = 3'd2,
    PhPlain  = 3'd4,
    PhQuoted = 3'd5,
    PhDone   = 3'd6
  } phase_e;

  // Membership in a character list; the first zero byte ends the list.
  function automatic logic in_set(input logic [SetW-1:0] set, input logic [CharW-1:0] c);
    logic             alive;
    logic             hit;
    logic [CharW-1:0] b;
    alive = 1'b1;
    hit   = 1'b0;
    for (int i = 0; i < SetChars; i++) begin
      b = set[i*CharW +: CharW];
      if (b == '0) begin
        alive = 1'b0;
      end
      if (alive && (b == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

/* sv/qft_if.sv */
// Valid/ready channel interfaces for characters in and tokens out.
`default_nettype none
interface qft_char_if;
  import qft_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface qft_res_if;
  import qft_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [CharW-1:0] char_value;
  logic             last;

  modport source (output valid, output kind, output char_value, output last, input ready);
  modport sink   (input valid, input kind, input char_value, input last, output ready);
endinterface
`default_nettype wire

/* sv/quoted_field_tokenizer_core.sv */
// Quoted field tokenizer: splits a zero-terminated character stream into fields.
// Characters enter one per transfer into an input register; a single pass of logic
// decodes each one against the tokenizer state and loads its results (up to four)
// into a small result buffer that drains one result per cycle unless out_chan
// stalls. A character with one result or none is taken every cycle unless out_chan
// stalls; one with more holds the input register until its last result goes out.
// Field characters are held back one character so that the trailing backslash
// rule can still rewrite a final escaped quote.
`default_nettype none
module quoted_field_tokenizer_core
  import qft_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [SetW-1:0]    cfg_data_i,
  qft_char_if.sink                in_chan,
  qft_res_if.source               out_chan
);

  localparam int unsigned SlotW = $clog2(MaxRes);

  // configuration
  logic [ModeW-1:0] mode_q;
  logic [CharW-1:0] max_flds_q;
  logic [SetW-1:0]  delim_q;
  logic [SetW-1:0]  quote_q;
  logic [SetW-1:0]  comment_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeReset;
      max_flds_q <= MaxFldReset;
      delim_q    <= DelimReset;
      quote_q    <= QuoteReset;
      comment_q  <= CommentReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMode:    mode_q     <= cfg_data_i[ModeW-1:0];
        CfgMaxFlds: max_flds_q <= cfg_data_i[CharW-1:0];
        CfgDelim:   delim_q    <= cfg_data_i;
        CfgQuote:   quote_q    <= cfg_data_i;
        CfgComment: comment_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // input register
  logic             inq_valid_q;
  logic [CharW-1:0] inq_char_q;
  logic             load;
  logic             out_fire;

  // result buffer
  kind_e            res_kind_q [MaxRes];
  logic [CharW-1:0] res_char_q [MaxRes];
  logic [ResCntW-1:0] res_n_q;

  assign out_fire = out_chan.valid && out_chan.ready;
  assign load     = inq_valid_q &&
                    ((res_n_q == '0) || ((res_n_q == ResCntW'(1)) && out_fire));
  assign in_chan.ready = !inq_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      inq_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      inq_char_q <= in_chan.char_code;
    end
  end

  // tokenizer state
  phase_e           phase_q, phase_d;
  logic [CharW-1:0] open_q, open_d;
  logic             esc_q, esc_d;
  logic             qwe_q, qwe_d;
  logic             fe_q, fe_d;
  logic [CharW-1:0] fcnt_q, fcnt_d;
  logic             held_v_q, held_v_d;
  logic [CharW-1:0] held_q, held_d;

  // decode
  logic             nz, is_del, is_com, is_q;
  phase_e           ph, ph_after_end;
  logic             reach_check, reach_open, reach_plain;
  logic             end_fld, wr_c, wr_bs, held_v_w;
  logic [CharW-1:0] fcnt_inc;
  logic             e_held, e_bs, e_fend, e_lend;
  kind_e            lend_kind;
  logic             slot_en   [MaxRes];
  kind_e            slot_kind [MaxRes];
  logic [CharW-1:0] slot_char [MaxRes];
  kind_e            new_kind  [MaxRes];
  logic [CharW-1:0] new_char  [MaxRes];
  logic [ResCntW-1:0] new_n;

  assign nz     = inq_char_q != '0;
  assign is_del = in_set(delim_q, inq_char_q);
  assign is_com = in_set(comment_q, inq_char_q);
  assign is_q   = nz && in_set(quote_q, inq_char_q);

  assign fcnt_inc     = (fcnt_q == CountMax) ? fcnt_q : fcnt_q + CharW'(1);
  assign ph_after_end = ((max_flds_q != '0) && (fcnt_inc >= max_flds_q)) ? PhDone :
                        (mode_q[ModeEmpty] ? PhCheck : PhSkip);

  always_comb begin
    ph = phase_q;
    if (phase_q == PhStart) begin
      ph = mode_q[ModeEmpty] ? PhCheck : PhSkip;
    end
  end

  always_comb begin
    phase_d   = ph;
    open_d    = open_q;
    esc_d     = esc_q;
    qwe_d     = qwe_q;
    fe_d      = fe_q;
    fcnt_d    = fcnt_q;
    held_v_d  = held_v_q;
    held_d    = held_q;
    held_v_w  = held_v_q;
    end_fld   = 1'b0;
    wr_c      = 1'b0;
    wr_bs     = 1'b0;
    e_held    = 1'b0;
    e_bs      = 1'b0;
    e_fend    = 1'b0;
    e_lend    = 1'b0;
    lend_kind = KindLineOk;
    reach_check = 1'b0;
    reach_open  = 1'b0;
    reach_plain = 1'b0;

    if (nz) begin
      qwe_d       = 1'b0;
      reach_check = ((ph == PhSkip) && !is_del) || (ph == PhCheck);
      reach_open  = reach_check && !is_com;
      reach_plain = (reach_open && !is_q) || (ph == PhPlain);
      if (reach_check && is_com) begin
        phase_d = PhDone;
      end
      if (reach_open) begin
        fe_d     = 1'b0;
        held_v_w = 1'b0;
        if (is_q) begin
          open_d  = inq_char_q;
          phase_d = PhQuoted;
        end else begin
          open_d  = '0;
          phase_d = PhPlain;
        end
      end
      if (reach_plain) begin
        if (is_del) begin
          if (mode_q[ModeEmpty]) begin
            fe_d = 1'b1;
          end
          end_fld = 1'b1;
        end else begin
          wr_c = 1'b1;
        end
      end
      if (ph == PhQuoted) begin
        if (inq_char_q == open_q) begin
          if (esc_q) begin
            wr_c  = 1'b1;
            esc_d = 1'b0;
            if (mode_q[ModeDos]) begin
              qwe_d = 1'b1;
            end
          end else begin
            end_fld = 1'b1;
          end
        end else if (!mode_q[ModeNoEsc] && (inq_char_q == Backslash)) begin
          esc_d = 1'b1;
        end else begin
          if (esc_q) begin
            wr_bs = 1'b1;
            esc_d = 1'b0;
          end
          wr_c = 1'b1;
        end
      end
      e_held = held_v_w && (end_fld || wr_c || wr_bs);
      e_bs   = wr_bs;
      e_fend = end_fld;
      if (end_fld) begin
        held_v_d = 1'b0;
        fcnt_d   = fcnt_inc;
        open_d   = '0;
        phase_d  = ph_after_end;
      end else if (wr_c) begin
        held_v_d = 1'b1;
        held_d   = inq_char_q;
      end else begin
        held_v_d = held_v_w;
      end
    end else begin
      // line end: one decode step, then return to line start
      e_lend = 1'b1;
      if ((ph == PhQuoted) && !qwe_q) begin
        lend_kind = KindLineOpen;
      end
      case (ph)
        PhCheck: begin
          end_fld = fe_q;
          e_held  = held_v_q && fe_q;
        end
        PhPlain: begin
          end_fld = 1'b1;
          e_held  = held_v_q;
        end
        PhQuoted: begin
          end_fld = 1'b1;
          if (esc_q) begin
            e_held = held_v_q;
            e_bs   = 1'b1;
          end else if (qwe_q) begin
            // escaped closing quote becomes a trailing backslash
            e_bs   = 1'b1;
          end else begin
            e_held = held_v_q;
          end
        end
        default: ;
      endcase
      e_fend   = end_fld;
      phase_d  = PhStart;
      open_d   = '0;
      esc_d    = 1'b0;
      qwe_d    = 1'b0;
      fe_d     = 1'b0;
      fcnt_d   = '0;
      held_v_d = 1'b0;
    end
  end

  // pack results in order: held char, backslash, field end, line end
  always_comb begin
    slot_en[0]   = e_held;
    slot_kind[0] = KindChar;
    slot_char[0] = held_q;
    slot_en[1]   = e_bs;
    slot_kind[1] = KindChar;
    slot_char[1] = Backslash;
    slot_en[2]   = e_fend;
    slot_kind[2] = KindFieldEnd;
    slot_char[2] = '0;
    slot_en[3]   = e_lend;
    slot_kind[3] = lend_kind;
    slot_char[3] = '0;
  end

  always_comb begin
    new_n = '0;
    for (int i = 0; i < MaxRes; i++) begin
      new_kind[i] = KindChar;
      new_char[i] = '0;
    end
    for (int i = 0; i < MaxRes; i++) begin
      if (slot_en[i]) begin
        new_kind[new_n[SlotW-1:0]] = slot_kind[i];
        new_char[new_n[SlotW-1:0]] = slot_char[i];
        new_n = new_n + ResCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStart;
      open_q   <= '0;
      esc_q    <= 1'b0;
      qwe_q    <= 1'b0;
      fe_q     <= 1'b0;
      fcnt_q   <= '0;
      held_v_q <= 1'b0;
    end else if (load) begin
      phase_q  <= phase_d;
      open_q   <= open_d;
      esc_q    <= esc_d;
      qwe_q    <= qwe_d;
      fe_q     <= fe_d;
      fcnt_q   <= fcnt_d;
      held_v_q <= held_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_n_q <= '0;
    end else if (load) begin
      res_n_q <= new_n;
    end else if (out_fire) begin
      res_n_q <= res_n_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < MaxRes; i++) begin
        res_kind_q[i] <= new_kind[i];
        res_char_q[i] <= new_char[i];
      end
    end else if (out_fire) begin
      // advance the queue by one result
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_kind_q[i] <= res_kind_q[i+1];
        res_char_q[i] <= res_char_q[i+1];
      end
    end
  end

  assign out_chan.valid      = res_n_q != '0;
  assign out_chan.kind       = res_kind_q[0];
  assign out_chan.char_value = res_char_q[0];
  assign out_chan.last       = res_n_q == ResCntW'(1);

  // checks
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_n_q <= ResCntW'(MaxRes))
    else $error("result buffer overfilled");

  a_line_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (inq_char_q == '0)) |=> (phase_q == PhStart) && !held_v_q && (fcnt_q == '0))
    else $error("state not cleared after line end");

  a_held_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_v_q |-> ((phase_q == PhPlain) || (phase_q == PhQuoted)))
    else $error("held character outside a field");

  a_esc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (esc_q || qwe_q) |-> (phase_q == PhQuoted))
    else $error("escape state outside a quoted field");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ((res_n_q == '0) || out_fire))
    else $error("results overwritten before transfer");

endmodule
`default_nettype wire

/* tb/quoted_field_tokenizer_core_tb.sv */
// Self-checking testbench for the quoted field tokenizer core.
`timescale 1ns / 1ps
module quoted_field_tokenizer_core_tb;
  import qft_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 16;
  localparam int HoldOff     = 400;

  localparam logic [CharW-1:0]   LineEnd  = 8'h00;
  localparam logic [CfgIdxW-1:0] SpareLo  = 3'd5;
  localparam logic [CfgIdxW-1:0] SpareHi  = 3'd7;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] value;
    logic             last;
  } token_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [SetW-1:0]    cfg_data_i;

  qft_char_if char_bus ();
  qft_res_if  tok_bus ();

  quoted_field_tokenizer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_chan    (char_bus),
    .out_chan   (tok_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted register copy and tokenizer state
  logic [ModeW-1:0] mode_r;
  logic [CharW-1:0] max_fields_r;
  logic [SetW-1:0]  delim_r;
  logic [SetW-1:0]  quote_r;
  logic [SetW-1:0]  comment_r;

  phase_e           tok_phase;
  logic [CharW-1:0] open_quote;
  logic             esc_pending;
  logic             quote_escaped;
  logic             field_pending;
  logic [CharW-1:0] field_count;
  logic             held_valid;
  logic [CharW-1:0] held_value;
  logic             quotes_ok;

  token_t step_tokens[$];
  token_t expected_tokens[$];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_off_left = 0;
  int chars_sent    = 0;
  int failures      = 0;
  int cycle_count   = 0;

  function automatic bit in_list(logic [SetW-1:0] list, logic [CharW-1:0] c);
    for (int i = 0; i < SetChars; i++) begin
      if (list[i*CharW +: CharW] == '0) return 1'b0;
      if (list[i*CharW +: CharW] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void emit_token(kind_e k, logic [CharW-1:0] v);
    token_t t;
    t.kind  = k;
    t.value = v;
    t.last  = 1'b0;
    step_tokens = {step_tokens, t};
  endfunction

  // Field characters leave one step late: flush the held one, hold the new one.
  function automatic void push_field_char(logic [CharW-1:0] c);
    if (held_valid) emit_token(KindChar, held_value);
    held_valid = 1'b1;
    held_value = c;
  endfunction

  function automatic void close_field();
    if (held_valid) emit_token(KindChar, held_value);
    held_valid = 1'b0;
    emit_token(KindFieldEnd, '0);
    if (field_count != CountMax) field_count++;
    open_quote = '0;
    if (max_fields_r != '0 && field_count >= max_fields_r) tok_phase = PhDone;
    else if (mode_r[ModeEmpty]) tok_phase = PhCheck;
    else tok_phase = PhSkip;
  endfunction

  function automatic void clear_line();
    tok_phase     = PhStart;
    open_quote    = '0;
    esc_pending   = 1'b0;
    quote_escaped = 1'b0;
    field_pending = 1'b0;
    field_count   = '0;
    held_valid    = 1'b0;
    held_value    = '0;
    quotes_ok     = 1'b1;
  endfunction

  function automatic void tokenize_char(logic [CharW-1:0] c);
    logic again;
    step_tokens.delete();
    if (c != LineEnd) quote_escaped = 1'b0;
    if (tok_phase == PhStart) tok_phase = mode_r[ModeEmpty] ? PhCheck : PhSkip;
    // The line end is examined by one phase only.
    do begin
      again = 1'b0;
      case (tok_phase)
        PhSkip: begin
          if (!in_list(delim_r, c)) begin
            tok_phase = PhCheck;
            again     = (c != LineEnd);
          end
        end
        PhCheck: begin
          if (in_list(comment_r, c)) begin
            tok_phase = PhDone;
          end else if (field_pending && c == LineEnd) begin
            close_field();
          end else begin
            field_pending = 1'b0;
            held_valid    = 1'b0;
            if (c != LineEnd && in_list(quote_r, c)) begin
              open_quote = c;
              tok_phase  = PhQuoted;
            end else begin
              open_quote = '0;
              tok_phase  = PhPlain;
              again      = (c != LineEnd);
            end
          end
        end
        PhPlain: begin
          if (in_list(delim_r, c)) begin
            if (mode_r[ModeEmpty]) field_pending = 1'b1;
            close_field();
          end else if (c == LineEnd) begin
            close_field();
          end else begin
            push_field_char(c);
          end
        end
        PhQuoted: begin
          if (c != LineEnd && c == open_quote) begin
            if (esc_pending) begin
              push_field_char(c);
              esc_pending = 1'b0;
              if (mode_r[ModeDos]) quote_escaped = 1'b1;
            end else begin
              close_field();
            end
          end else if (!mode_r[ModeNoEsc] && c == Backslash) begin
            esc_pending = 1'b1;
          end else begin
            if (esc_pending) begin
              push_field_char(Backslash);
              esc_pending = 1'b0;
            end
            if (c == LineEnd) begin
              // DOS rule: a final escaped quote turns into a trailing backslash
              if (quote_escaped) begin
                held_valid = 1'b1;
                held_value = Backslash;
              end else begin
                quotes_ok = 1'b0;
              end
              close_field();
            end else begin
              push_field_char(c);
            end
          end
        end
        default: ;
      endcase
    end while (again);
    if (c == LineEnd) begin
      emit_token(quotes_ok ? KindLineOk : KindLineOpen, '0);
      clear_line();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    expected_tokens = {expected_tokens, step_tokens};
  endfunction

  // Register write; the predictor copy follows once the write has landed.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SetW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMode:    mode_r       = data[ModeW-1:0];
      CfgMaxFlds: max_fields_r = data[CharW-1:0];
      CfgDelim:   delim_r      = data;
      CfgQuote:   quote_r      = data;
      CfgComment: comment_r    = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_char(logic [CharW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    do @(posedge clk_i); while (char_bus.ready !== 1'b1);
    tokenize_char(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(LineEnd);
  endtask

  // Drop valid, wait for every predicted token, then let the core go quiet.
  task automatic settle();
    char_bus.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [CharW-1:0] random_text();
    return CharW'($urandom_range(255, 1));
  endfunction

  function automatic logic [CharW-1:0] pick_from(logic [SetW-1:0] list);
    int n;
    int k;
    n = 0;
    while (n < SetChars && list[n*CharW +: CharW] != '0) n++;
    if (n == 0) return random_text();
    k = $urandom_range(n - 1);
    return list[k*CharW +: CharW];
  endfunction

  // Up to four members, ended by a zero byte when fewer than four; bytes after it stay random.
  function automatic logic [SetW-1:0] random_list();
    logic [SetW-1:0] list;
    int              n;
    list = $urandom;
    n    = $urandom_range(SetChars);
    for (int i = 0; i < SetChars; i++) begin
      if (i < n) list[i*CharW +: CharW] = random_text();
      else if (i == n) list[i*CharW +: CharW] = '0;
    end
    return list;
  endfunction

  task automatic randomize_regs();
    logic [SetW-1:0] word;
    write_reg(CfgMode, $urandom);
    word = $urandom;
    case ($urandom_range(3))
      0: word[CharW-1:0] = '0;
      1: word[CharW-1:0] = CharW'($urandom_range(3, 1));
      2: word[CharW-1:0] = CountMax;
      default: ;
    endcase
    write_reg(CfgMaxFlds, word);
    write_reg(CfgDelim, random_list());
    write_reg(CfgQuote, random_list());
    write_reg(CfgComment, random_list());
  endtask

  // A line built from fields: delimiters, plain words, quoted text, comments.
  task automatic send_random_line();
    int               nfields;
    logic [CharW-1:0] q;
    nfields = $urandom_range(4);
    repeat (nfields) begin
      repeat ($urandom_range(2)) send_char(pick_from(delim_r));
      case ($urandom_range(9))
        0: begin
          send_char(pick_from(comment_r));
          repeat ($urandom_range(3)) send_char(random_text());
        end
        1, 2, 3, 4: begin
          q = pick_from(quote_r);
          send_char(q);
          repeat ($urandom_range(4)) begin
            case ($urandom_range(5))
              0: begin
                send_char(Backslash);
                send_char(q);
              end
              1: begin
                send_char(Backslash);
                send_char(random_text());
              end
              default: send_char(random_text());
            endcase
          end
          if ($urandom_range(5) != 0) begin
            send_char(q);
          end else if ($urandom_range(1) != 0) begin
            // leave the quote open right after an escaped quote
            send_char(Backslash);
            send_char(q);
          end
        end
        default: repeat ($urandom_range(4, 1)) send_char(random_text());
      endcase
    end
    if ($urandom_range(3) == 0) send_char(pick_from(delim_r));
    send_char(LineEnd);
  endtask

  task automatic random_lines(int budget);
    int start;
    start = chars_sent;
    while (chars_sent - start < budget) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(12, 1)) send_char(CharW'($urandom_range(255)));
        send_char(LineEnd);
      end else begin
        send_random_line();
      end
    end
  endtask

  task automatic test_directed_lines();
    send_line("");
    send_line("\"\\\"b\"#");
    send_char(8'hFF);
    send_char(8'h01);
    send_line("'\\");
    settle();
    write_reg(CfgMode, (1 << ModeEmpty) | (1 << ModeDos));
    send_line("a  \"\\\"");
    send_line("b ");
    settle();
    write_reg(CfgMode, 1 << ModeNoEsc);
    write_reg(CfgMaxFlds, 2);
    send_line("'a\\' b c");
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(CfgMode, '1);
    write_reg(CfgMaxFlds, CountMax);
    write_reg(CfgDelim, '1);
    write_reg(CfgQuote, '0);
    write_reg(CfgComment, '0);
    random_lines(10);
    settle();
    write_reg(CfgMode, '0);
    write_reg(CfgMaxFlds, 1);
    write_reg(CfgDelim, '0);
    write_reg(CfgQuote, '1);
    write_reg(CfgComment, '1);
    random_lines(10);
    settle();
  endtask

  task automatic test_spare_index();
    write_reg(CfgMode, '0);
    write_reg(CfgMaxFlds, '0);
    write_reg(CfgDelim, DelimReset);
    write_reg(CfgQuote, QuoteReset);
    write_reg(CfgComment, CommentReset);
    for (int i = SpareLo; i <= SpareHi; i++) write_reg(CfgIdxW'(i), $urandom);
    random_lines(8);
    settle();
  endtask

  task automatic test_random_traffic(int send_pct, int stall_rate, int budget);
    send_idle_pct = send_pct;
    stall_pct     = stall_rate;
    randomize_regs();
    random_lines(budget);
    settle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    randomize_regs();
    hold_off_left = HoldOff;
    random_lines(20);
    settle();
  endtask

  // Receiver: random stalls, or a counted hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      tok_bus.ready <= 1'b0;
      hold_off_left--;
    end else begin
      tok_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni && tok_bus.valid === 1'b1 && tok_bus.ready === 1'b1) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected transfer: kind %0d char_value %0h last %0b",
               tok_bus.kind, tok_bus.char_value, tok_bus.last);
        failures++;
      end else begin
        want = expected_tokens.pop_front();
        if (tok_bus.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, tok_bus.kind);
          failures++;
        end
        if (tok_bus.char_value !== want.value) begin
          $error("char_value: expected %0h, got %0h", want.value, tok_bus.char_value);
          failures++;
        end
        if (tok_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, tok_bus.last);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    tok_bus.ready      = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CfgMode;
    cfg_data_i         = '0;
    rst_ni             = 1'b0;
    mode_r             = ModeReset;
    max_fields_r       = MaxFldReset;
    delim_r            = DelimReset;
    quote_r            = QuoteReset;
    comment_r          = CommentReset;
    clear_line();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_lines();
    test_register_extremes();
    test_spare_index();
    test_random_traffic(0, 0, 18);
    test_random_traffic(70, 0, 18);
    test_random_traffic(0, 70, 18);
    test_random_traffic(36, 36, 18);
    test_backpressure();

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/qft_pkg.sv
sv/qft_if.sv
sv/quoted_field_tokenizer_core.sv
tb/quoted_field_tokenizer_core_tb.sv
